// ----- src/amp_soft_start_relay_sequencer_defines.svh -----
// Assertion macros for the amplifier soft-start relay sequencer.
`ifndef AMP_SOFT_START_RELAY_SEQUENCER_DEFINES_SVH
`define AMP_SOFT_START_RELAY_SEQUENCER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define ASRS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASRS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- src/asrs_pkg.sv -----
// Shared types and constants of the amplifier soft-start relay sequencer.
package asrs_pkg;

   // Sequencer phases, one-hot
   typedef enum logic [8:0] {
      PH_OFF      = 9'b000000001,
      PH_NEUTRAL  = 9'b000000010,
      PH_RESISTOR = 9'b000000100,
      PH_SETTLE   = 9'b000001000,
      PH_ON       = 9'b000010000,
      PH_SPK_OFF  = 9'b000100000,
      PH_LIVE_OFF = 9'b001000000,
      PH_NEUT_OFF = 9'b010000000,
      PH_BLINK    = 9'b100000000
   } asrs_phase_type;

   // Phase numbers shown on the result channel
   localparam logic [3:0] PHASE_CODE_OFF      = 4'd0;
   localparam logic [3:0] PHASE_CODE_NEUTRAL  = 4'd1;
   localparam logic [3:0] PHASE_CODE_RESISTOR = 4'd2;
   localparam logic [3:0] PHASE_CODE_SETTLE   = 4'd3;
   localparam logic [3:0] PHASE_CODE_ON       = 4'd4;
   localparam logic [3:0] PHASE_CODE_SPK_OFF  = 4'd5;
   localparam logic [3:0] PHASE_CODE_LIVE_OFF = 4'd6;
   localparam logic [3:0] PHASE_CODE_NEUT_OFF = 4'd7;
   localparam logic [3:0] PHASE_CODE_BLINK    = 4'd8;

   // Register indexes of the configuration port
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESISTOR_TICKS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_TICKS   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFF_BLINK      = 2'd2;

   // Configuration register set
   typedef struct packed {
      logic [7:0] resistor_ticks;
      logic [7:0] settle_ticks;
      logic [7:0] off_blink_ticks;
   } asrs_cfg_type;

   localparam asrs_cfg_type CFG_RESET = '{
      resistor_ticks:  8'd20,
      settle_ticks:    8'd20,
      off_blink_ticks: 8'd10
   };

   // Latched relay and lamp drives
   typedef struct packed {
      logic neutral;
      logic resistor_live;
      logic direct_live;
      logic lamp;
      logic speaker_n;
   } asrs_drive_type;

   localparam asrs_drive_type DRIVE_RESET = '{
      neutral:       1'b0,
      resistor_live: 1'b0,
      direct_live:   1'b0,
      lamp:          1'b0,
      speaker_n:     1'b1
   };

   // Map a phase to its number
   function automatic logic [3:0] phase_code(asrs_phase_type ph);
      logic [3:0] code;
      case (ph)
         PH_OFF:      code = PHASE_CODE_OFF;
         PH_NEUTRAL:  code = PHASE_CODE_NEUTRAL;
         PH_RESISTOR: code = PHASE_CODE_RESISTOR;
         PH_SETTLE:   code = PHASE_CODE_SETTLE;
         PH_ON:       code = PHASE_CODE_ON;
         PH_SPK_OFF:  code = PHASE_CODE_SPK_OFF;
         PH_LIVE_OFF: code = PHASE_CODE_LIVE_OFF;
         PH_NEUT_OFF: code = PHASE_CODE_NEUT_OFF;
         PH_BLINK:    code = PHASE_CODE_BLINK;
         default:     code = PHASE_CODE_OFF;
      endcase
      return code;
   endfunction

endpackage

// ----- src/asrs_next_state.sv -----
// Next-state logic of the sequencer for one tick.
module asrs_next_state #(
   parameter int unsigned COUNT_BITS = 8
) (
   input  asrs_pkg::asrs_phase_type phase_q,
   input  logic [COUNT_BITS-1:0]    count_q,
   input  logic                     blink_q,
   input  logic                     prev_pressed_q,
   input  asrs_pkg::asrs_drive_type drive_q,
   input  asrs_pkg::asrs_cfg_type   cfg,
   input  logic                     switch_pin,
   output asrs_pkg::asrs_phase_type phase_d,
   output logic [COUNT_BITS-1:0]    count_d,
   output logic                     blink_d,
   output logic                     prev_pressed_d,
   output asrs_pkg::asrs_drive_type drive_d
);
   import asrs_pkg::*;

   localparam int unsigned CMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic                  pressed;
   logic                  press;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  resistor_done;
   logic                  settle_done;
   logic                  blink_done;

   // Detect the press edge and the timer end conditions
   always_comb begin
      pressed       = ~switch_pin;
      press         = pressed & ~prev_pressed_q;
      count_inc     = (count_q == CNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
      resistor_done = (CMP_BITS'(count_inc) >= CMP_BITS'(cfg.resistor_ticks))
                      || (count_inc == CNT_MAX);
      settle_done   = (CMP_BITS'(count_inc) >= CMP_BITS'(cfg.settle_ticks))
                      || (count_inc == CNT_MAX);
      blink_done    = (CMP_BITS'(count_q) >= CMP_BITS'(cfg.off_blink_ticks))
                      || (count_q == CNT_MAX);
   end

   // Advance the phase and update the latched drives
   always_comb begin
      phase_d        = phase_q;
      count_d        = count_q;
      blink_d        = blink_q;
      prev_pressed_d = pressed;
      drive_d        = drive_q;
      case (phase_q)
         PH_OFF: begin
            drive_d = DRIVE_RESET;
            if (press) begin
               phase_d = PH_NEUTRAL;
            end
         end
         PH_NEUTRAL: begin
            drive_d.neutral = 1'b1;
            drive_d.lamp    = 1'b1;
            blink_d         = 1'b1;
            count_d         = '0;
            phase_d         = PH_RESISTOR;
         end
         PH_RESISTOR: begin
            drive_d.resistor_live = 1'b1;
            blink_d               = ~blink_q;
            drive_d.lamp          = ~blink_q;
            if (resistor_done) begin
               count_d = '0;
               phase_d = PH_SETTLE;
            end else begin
               count_d = count_inc;
            end
         end
         PH_SETTLE: begin
            drive_d.direct_live   = 1'b1;
            drive_d.resistor_live = 1'b0;
            blink_d               = ~blink_q;
            drive_d.lamp          = ~blink_q;
            if (settle_done) begin
               count_d = '0;
               phase_d = PH_ON;
            end else begin
               count_d = count_inc;
            end
         end
         PH_ON: begin
            drive_d.lamp      = 1'b1;
            drive_d.speaker_n = 1'b0;
            if (press) begin
               phase_d = PH_SPK_OFF;
            end
         end
         PH_SPK_OFF: begin
            drive_d.lamp      = 1'b0;
            drive_d.speaker_n = 1'b1;
            phase_d           = PH_LIVE_OFF;
         end
         PH_LIVE_OFF: begin
            drive_d.lamp        = 1'b1;
            drive_d.direct_live = 1'b0;
            phase_d             = PH_NEUT_OFF;
         end
         PH_NEUT_OFF: begin
            drive_d.lamp    = 1'b0;
            drive_d.neutral = 1'b0;
            count_d         = '0;
            phase_d         = PH_BLINK;
         end
         PH_BLINK: begin
            blink_d      = ~blink_q;
            drive_d.lamp = ~blink_q;
            if (blink_done) begin
               count_d = '0;
               phase_d = PH_OFF;
            end else begin
               count_d = count_inc;
            end
         end
         default: begin
            phase_d = PH_OFF;
         end
      endcase
   end

endmodule

// ----- src/amp_soft_start_relay_sequencer.sv -----
// Top level of the amplifier soft-start relay sequencer.
//
// Usage: each transfer on the req_ channel is one 100 ms tick carrying the raw,
// active-low power switch pin. Every tick yields exactly one transfer on the
// rsp_ channel with the latched relay and lamp drives and the phase after the
// tick. The csr_ port writes the three timing registers; the user must
// write them only while no tick is in flight, as the block does not enforce it.
// Latency: a result is valid in the cycle after its tick is accepted.
// Throughput: one tick per cycle while rsp_ready is high, set by the single result
// register; a new tick is taken in the same cycle the pending result is taken.
// Stall: while rsp_ready is low and a result waits, req_ready is low and the
// sequencer state holds.
// Reset: the phase goes to off, all relays open, lamp dark, speaker disabled,
// and the timing registers return to 20, 20 and 10 ticks. A switch held
// pressed through reset counts as a press on the first tick.
`include "amp_soft_start_relay_sequencer_defines.svh"

module amp_soft_start_relay_sequencer #(
   parameter int unsigned COUNT_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_switch_pin,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_neutral_relay,
   output logic                                 rsp_resistor_live_relay,
   output logic                                 rsp_direct_live_relay,
   output logic                                 rsp_power_lamp,
   output logic                                 rsp_speaker_relay_n,
   output logic [3:0]                           rsp_phase,
   input  logic                                 csr_wr_en,
   input  logic [asrs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [7:0]                           csr_wdata
);
   import asrs_pkg::*;

   asrs_cfg_type          cfg_ff, cfg_in;
   asrs_phase_type        phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  blink_ff, blink_in;
   logic                  prev_pressed_ff, prev_pressed_in;
   asrs_drive_type        drive_ff, drive_in;
   logic [3:0]            rsp_phase_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_xfer;

   // Take a tick whenever the result register is free or being emptied
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_xfer  = req_valid & req_ready;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RESISTOR_TICKS: cfg_in.resistor_ticks  = csr_wdata;
            CSR_SETTLE_TICKS:   cfg_in.settle_ticks    = csr_wdata;
            CSR_OFF_BLINK:      cfg_in.off_blink_ticks = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Compute the effect of one tick
   asrs_next_state #(
      .COUNT_BITS (COUNT_BITS)
   ) u_next_state (
      .phase_q        (phase_ff),
      .count_q        (count_ff),
      .blink_q        (blink_ff),
      .prev_pressed_q (prev_pressed_ff),
      .drive_q        (drive_ff),
      .cfg            (cfg_ff),
      .switch_pin     (req_switch_pin),
      .phase_d        (phase_in),
      .count_d        (count_in),
      .blink_d        (blink_in),
      .prev_pressed_d (prev_pressed_in),
      .drive_d        (drive_in)
   );

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Registers: configuration, sequencer state and result
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff          <= CFG_RESET;
         phase_ff        <= PH_OFF;
         count_ff        <= '0;
         blink_ff        <= 1'b0;
         prev_pressed_ff <= 1'b0;
         drive_ff        <= DRIVE_RESET;
         rsp_phase_ff    <= PHASE_CODE_OFF;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            phase_ff        <= phase_in;
            count_ff        <= count_in;
            blink_ff        <= blink_in;
            prev_pressed_ff <= prev_pressed_in;
            drive_ff        <= drive_in;
            rsp_phase_ff    <= phase_code(phase_in);
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_neutral_relay       = drive_ff.neutral;
   assign rsp_resistor_live_relay = drive_ff.resistor_live;
   assign rsp_direct_live_relay   = drive_ff.direct_live;
   assign rsp_power_lamp          = drive_ff.lamp;
   assign rsp_speaker_relay_n     = drive_ff.speaker_n;
   assign rsp_phase               = rsp_phase_ff;

   // Speaker only enabled with the supply fully up on the direct path
   `ASRS_ASSERT_ALWAYS(a_speaker_needs_power, clock, reset, rsp_speaker_relay_n || (rsp_neutral_relay && rsp_direct_live_relay && !rsp_resistor_live_relay), "speaker enabled without full power")
   // Never close both live paths at once
   `ASRS_ASSERT_ALWAYS(a_live_paths_exclusive, clock, reset, !(rsp_resistor_live_relay && rsp_direct_live_relay), "resistor and direct live relays both closed")
   // Neutral phase always moves on to the resistor phase
   `ASRS_ASSERT_NEXT(a_neutral_to_resistor, clock, reset, req_xfer && (phase_ff == PH_NEUTRAL), rsp_valid && (rsp_phase == PHASE_CODE_RESISTOR), "neutral phase did not advance")

endmodule
